### design/tsaf_pkg.sv
// tsaf_pkg: shared constants, types and the blend rounding helper
// for the triangle scanline alpha fill block; no dependencies
`timescale 1ns / 1ps

package tsaf_pkg;

	localparam int FRAME_WIDTH  = 64;
	localparam int FRAME_HEIGHT = 64;
	localparam int STORE_DEPTH  = 4096;
	localparam int ADDR_W       = 12;
	localparam int PIX_W        = 32;
	localparam int COL_W        = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
	localparam int ROW_W        = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
	localparam int HALF_PIXEL   = 8;
	localparam int NUM_W        = 36;
	localparam int DEN_W        = 20;
	localparam int CNT_W        = $clog2(NUM_W);
	localparam int LIN_W        = 24;

	localparam logic OP_DRAW = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgba_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  data;
	} wr_req_t;

	// rounded divide by 255 for values up to 255 * 255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		logic [16:0] s;
		t = {1'b0, x} + 17'd127;
		s = t + 17'd1 + (t >> 8);
		return s[15:8];
	endfunction

endpackage

### design/tsaf_ram.sv
// tsaf_ram: pixel store, one write and one registered read port
// depends on tsaf_pkg
`timescale 1ns / 1ps

module tsaf_ram import tsaf_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [PIX_W-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [PIX_W-1:0]  rdata
);

	logic [PIX_W-1:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/tsaf_div.sv
// tsaf_div: restoring divider, one quotient bit per cycle, gives floor and ceil
// of a signed numerator over a positive denominator; depends on tsaf_pkg
`timescale 1ns / 1ps

module tsaf_div import tsaf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output logic                    done,
	output logic signed [NUM_W:0]   q_floor,
	output logic signed [NUM_W:0]   q_ceil
);

	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   rem_sh;
	logic             fits;
	logic [DEN_W:0]   rem_nx;
	logic signed [NUM_W:0] qu;
	logic signed [NUM_W:0] up;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};
	assign rem_nx = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1];
			quo_q <= num[NUM_W-1] ? (-num) : num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= rem_nx[DEN_W-1:0];
		end
	end

	assign qu      = {1'b0, quo_q};
	assign up      = qu + (NUM_W+1)'(rem_q != '0);
	assign q_floor = neg_q ? -up : qu;
	assign q_ceil  = neg_q ? -qu : up;
	assign done    = done_q;

endmodule

### design/tsaf_blend.sv
// tsaf_blend: read-modify-write pipeline that blends a constant color into
// stored pixels, one pixel per cycle; depends on tsaf_pkg
`timescale 1ns / 1ps

module tsaf_blend import tsaf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              issue,
	input  logic [ADDR_W-1:0] issue_addr,
	input  rgba_t             color,
	input  logic [PIX_W-1:0]  rdata,
	output wr_req_t           wr,
	output logic              busy
);

	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              valid_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [15:0]       sum_s2 [4];
	rgba_t             dst;
	logic [7:0]        ia;

	assign dst = rgba_t'(rdata);
	assign ia  = 8'd255 - color.alpha;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1   <= issue_addr;
		addr_s2   <= addr_s1;
		sum_s2[0] <= {8'd0, color.red} * {8'd0, color.alpha} + {8'd0, dst.red} * {8'd0, ia};
		sum_s2[1] <= {8'd0, color.green} * {8'd0, color.alpha} + {8'd0, dst.green} * {8'd0, ia};
		sum_s2[2] <= {8'd0, color.blue} * {8'd0, color.alpha} + {8'd0, dst.blue} * {8'd0, ia};
		sum_s2[3] <= {8'd0, color.alpha} * 16'd255 + {8'd0, dst.alpha} * {8'd0, ia};
	end

	assign wr.we   = valid_s2;
	assign wr.addr = addr_s2;
	assign wr.data = {div255(sum_s2[3]), div255(sum_s2[2]), div255(sum_s2[1]),
		div255(sum_s2[0])};
	assign busy    = valid_s1 | valid_s2;

endmodule

### design/triangle_scanline_alpha_fill.sv
// triangle_scanline_alpha_fill: top level, draw and read sequencer around the
// pixel store; depends on tsaf_pkg, tsaf_ram, tsaf_div, tsaf_blend
//
// channel  direction  payload
// s_axis   in         tuser: operation; tdata: vertices, color, pixel_index
// m_axis   out        tdata: read_red, read_green, read_blue, read_alpha
//
// after reset the store is zeroed, one entry a cycle, with s_axis_tready low
// a read goes through the registered store read port to the output register
// a draw passes the sort and range setup states, then per row runs the edge dividers
// and blends one pixel per cycle of the span, then drains the blend pipeline
// one item is in work at a time; a held read result stalls only the next read
`timescale 1ns / 1ps

module triangle_scanline_alpha_fill import tsaf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,  // vertex0_x, vertex0_y, vertex1_x, vertex1_y,
	                                    // vertex2_x, vertex2_y, fill_red, fill_green,
	                                    // fill_blue, fill_alpha, pixel_index, zero fill
	input  logic         s_axis_tuser,  // operation
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [31:0]  m_axis_tdata   // read_red, read_green, read_blue, read_alpha
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_SORT  = 4'd2;
	localparam logic [3:0] S_RANGE = 4'd3;
	localparam logic [3:0] S_EDGE  = 4'd4;
	localparam logic [3:0] S_DIVST = 4'd5;
	localparam logic [3:0] S_DIVW  = 4'd6;
	localparam logic [3:0] S_SPAN  = 4'd7;
	localparam logic [3:0] S_PIX   = 4'd8;
	localparam logic [3:0] S_DRAIN = 4'd9;
	localparam logic [3:0] S_RD    = 4'd10;

	logic [3:0]        state_q;
	logic [ADDR_W-1:0] clr_q;
	logic signed [15:0] in_x_q [3];
	logic signed [15:0] in_y_q [3];
	logic signed [15:0] vx_q [3];
	logic signed [15:0] vy_q [3];
	rgba_t             color_q;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_W-1:0]  row_end_q;
	logic [COL_W-1:0]  col_q;
	logic [COL_W-1:0]  col_end_q;
	logic signed [32:0] pl1_q, ps1_q;
	logic signed [34:0] pl2_q, ps2_q;
	logic [15:0]       hl_q, hs_q;
	logic signed [NUM_W:0] fl_l_q, cl_l_q, fl_s_q, cl_s_q;
	logic              out_valid_q;
	logic [PIX_W-1:0]  out_data_q;

	logic              in_xfer;
	logic              rd_xfer;
	logic signed [15:0] sx [3];
	logic signed [15:0] sy [3];
	logic signed [15:0] tmp;
	logic signed [12:0] y0c, y2c;
	logic signed [16:0] h_all;
	logic              skip;
	logic signed [17:0] ry;
	logic signed [15:0] sax, sbx;
	logic signed [16:0] say, sby;
	logic signed [16:0] hs;
	logic signed [NUM_W-1:0] num_l, num_s;
	logic [DEN_W-1:0]  den_l, den_s;
	logic              div_start;
	logic              done_l, done_s;
	logic signed [NUM_W:0] qf_l, qc_l, qf_s, qc_s;
	logic signed [NUM_W:0] lo, hi, lo_c, hi_c;
	logic              last_row;
	logic [LIN_W-1:0]  pix_lin;
	logic              pix_issue;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [PIX_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [PIX_W-1:0]  ram_rdata;
	wr_req_t           blend_wr;
	logic              blend_busy;
	logic              out_load;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid & s_axis_tready;
	assign rd_xfer       = in_xfer & (s_axis_tuser == OP_READ);

	// stable three-element sort by y
	always_comb begin
		tmp = '0;
		sx[0] = in_x_q[0]; sx[1] = in_x_q[1]; sx[2] = in_x_q[2];
		sy[0] = in_y_q[0]; sy[1] = in_y_q[1]; sy[2] = in_y_q[2];
		if (sy[0] > sy[1]) begin
			tmp = sx[0]; sx[0] = sx[1]; sx[1] = tmp;
			tmp = sy[0]; sy[0] = sy[1]; sy[1] = tmp;
		end
		if (sy[1] > sy[2]) begin
			tmp = sx[1]; sx[1] = sx[2]; sx[2] = tmp;
			tmp = sy[1]; sy[1] = sy[2]; sy[2] = tmp;
		end
		if (sy[0] > sy[1]) begin
			tmp = sx[0]; sx[0] = sx[1]; sx[1] = tmp;
			tmp = sy[0]; sy[0] = sy[1]; sy[1] = tmp;
		end
	end

	// row range and degenerate checks
	always_comb begin
		y0c   = 13'((17'(vy_q[0]) + 17'sd15) >>> 4);
		y2c   = 13'(vy_q[2] >>> 4);
		if (y0c < 13'sd0) y0c = 13'sd0;
		if (y2c > 13'(FRAME_HEIGHT - 1)) y2c = 13'(FRAME_HEIGHT - 1);
		h_all = 17'(vy_q[2]) - 17'(vy_q[0]);
		skip  = (color_q.alpha == 8'd0) || (y0c > y2c) || (h_all < 17'sd8);
	end

	// edge selection for the current row
	always_comb begin
		ry = $signed({{(18 - ROW_W - 4){1'b0}}, row_q, 4'b0000});
		if (ry < 18'(vy_q[1])) begin
			if (17'(vy_q[1]) - 17'(vy_q[0]) > 17'(HALF_PIXEL)) begin
				sax = vx_q[0]; say = 17'(vy_q[0]); sbx = vx_q[1]; sby = 17'(vy_q[1]);
			end else begin
				sax = vx_q[1]; say = 17'sd0; sbx = vx_q[1]; sby = 17'sd1;
			end
		end else begin
			if (17'(vy_q[2]) - 17'(vy_q[1]) > 17'(HALF_PIXEL)) begin
				sax = vx_q[1]; say = 17'(vy_q[1]); sbx = vx_q[2]; sby = 17'(vy_q[2]);
			end else begin
				sax = vx_q[2]; say = 17'sd0; sbx = vx_q[2]; sby = 17'sd1;
			end
		end
		hs = sby - say;
	end

	assign num_l     = NUM_W'(pl1_q) + NUM_W'(pl2_q);
	assign num_s     = NUM_W'(ps1_q) + NUM_W'(ps2_q);
	assign den_l     = {hl_q, 4'b0000};
	assign den_s     = {hs_q, 4'b0000};
	assign div_start = (state_q == S_DIVST);

	tsaf_div u_div_long (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num     (num_l),
		.den     (den_l),
		.done    (done_l),
		.q_floor (qf_l),
		.q_ceil  (qc_l)
	);

	tsaf_div u_div_short (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num     (num_s),
		.den     (den_s),
		.done    (done_s),
		.q_floor (qf_s),
		.q_ceil  (qc_s)
	);

	// span bounds clamped to the frame
	always_comb begin
		lo   = (cl_s_q < cl_l_q) ? cl_s_q : cl_l_q;
		hi   = (fl_s_q > fl_l_q) ? fl_s_q : fl_l_q;
		lo_c = (lo < 0) ? '0 : lo;
		hi_c = (hi > (NUM_W+1)'(FRAME_WIDTH - 1)) ? (NUM_W+1)'(FRAME_WIDTH - 1) : hi;
	end

	assign last_row  = (row_q == row_end_q);
	assign pix_lin   = LIN_W'(row_q) * LIN_W'(FRAME_WIDTH) + LIN_W'(col_q);
	assign pix_issue = (state_q == S_PIX) && (pix_lin < LIN_W'(STORE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(STORE_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_xfer) state_q <= (s_axis_tuser == OP_READ) ? S_RD : S_SORT;
				end
				S_SORT:  state_q <= S_RANGE;
				S_RANGE: state_q <= skip ? S_IDLE : S_EDGE;
				S_EDGE:  state_q <= S_DIVST;
				S_DIVST: state_q <= S_DIVW;
				S_DIVW: begin
					if (done_l && done_s) state_q <= S_SPAN;
				end
				S_SPAN: begin
					if (lo_c > hi_c) state_q <= last_row ? S_DRAIN : S_EDGE;
					else state_q <= S_PIX;
				end
				S_PIX: begin
					if (col_q == col_end_q) state_q <= last_row ? S_DRAIN : S_EDGE;
				end
				S_DRAIN: begin
					if (!blend_busy) state_q <= S_IDLE;
				end
				S_RD: begin
					if (!out_valid_q || m_axis_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			in_x_q[0] <= s_axis_tdata[15:0];
			in_y_q[0] <= s_axis_tdata[31:16];
			in_x_q[1] <= s_axis_tdata[47:32];
			in_y_q[1] <= s_axis_tdata[63:48];
			in_x_q[2] <= s_axis_tdata[79:64];
			in_y_q[2] <= s_axis_tdata[95:80];
			color_q   <= s_axis_tdata[127:96];
		end
		if (state_q == S_SORT) begin
			vx_q[0] <= sx[0]; vx_q[1] <= sx[1]; vx_q[2] <= sx[2];
			vy_q[0] <= sy[0]; vy_q[1] <= sy[1]; vy_q[2] <= sy[2];
		end
		if (state_q == S_RANGE) begin
			row_q     <= y0c[ROW_W-1:0];
			row_end_q <= y2c[ROW_W-1:0];
		end
		if (state_q == S_EDGE) begin
			pl1_q <= vx_q[0] * h_all;
			pl2_q <= (17'(vx_q[2]) - 17'(vx_q[0])) * (ry - 18'(vy_q[0]));
			ps1_q <= sax * hs;
			ps2_q <= (17'(sbx) - 17'(sax)) * (ry - 18'(say));
			hl_q  <= h_all[15:0];
			hs_q  <= hs[15:0];
		end
		if (state_q == S_DIVW) begin
			fl_l_q <= qf_l;
			cl_l_q <= qc_l;
			fl_s_q <= qf_s;
			cl_s_q <= qc_s;
		end
		if (state_q == S_SPAN) begin
			col_q     <= lo_c[COL_W-1:0];
			col_end_q <= hi_c[COL_W-1:0];
			if (lo_c > hi_c && !last_row) row_q <= row_q + 1'b1;
		end
		if (state_q == S_PIX) begin
			col_q <= col_q + 1'b1;
			if (col_q == col_end_q && !last_row) row_q <= row_q + 1'b1;
		end
	end

	assign ram_we    = (state_q == S_CLEAR) | blend_wr.we;
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : blend_wr.addr;
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : blend_wr.data;
	assign ram_re    = rd_xfer | pix_issue;
	assign ram_raddr = rd_xfer ? s_axis_tdata[139:128] : pix_lin[ADDR_W-1:0];

	tsaf_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tsaf_blend u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue      (pix_issue),
		.issue_addr (pix_lin[ADDR_W-1:0]),
		.color      (color_q),
		.rdata      (ram_rdata),
		.wr         (blend_wr),
		.busy       (blend_busy)
	);

	assign out_load = (state_q == S_RD) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_data_q <= ram_rdata;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_no_blend_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !blend_wr.we)
		else $error("blend write during store clear");
	a_read_goes_to_rd: assert property (@(posedge clk) disable iff (!arst_n)
		rd_xfer |=> (state_q == S_RD))
		else $error("read transfer did not enter read state");
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !blend_busy)
		else $error("blend pipeline busy while idle");
	a_div_done_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> !done_l && !done_s)
		else $error("divider done flag not cleared on start");
`endif

endmodule

### tb/tsaf_checker.sv
// tsaf_checker: watches both stream channels of the triangle fill block, keeps
// its own copy of the pixel store and checks every read result in order
// depends on tsaf_pkg for the pixel layout
`timescale 1ns / 1ps

module tsaf_checker import tsaf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,
	input  logic         s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [31:0]  m_axis_tdata,
	output int           fail_count,
	output int           pixels_pending
);

	rgba_t shadow_frame [STORE_DEPTH];
	rgba_t pixels_due [$];

	function automatic longint fdiv(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && ((n < 0) != (d < 0)))
			q--;
		return q;
	endfunction

	function automatic longint cdiv(longint n, longint d);
		return -fdiv(-n, d);
	endfunction

	function automatic logic [7:0] round255(int unsigned x);
		return 8'((x + 127) / 255);
	endfunction

	function automatic rgba_t mix_pixel(rgba_t dst, rgba_t src);
		rgba_t o;
		int unsigned a, ia;
		a = src.alpha;
		ia = 255 - a;
		o.red   = round255(src.red * a + dst.red * ia);
		o.green = round255(src.green * a + dst.green * ia);
		o.blue  = round255(src.blue * a + dst.blue * ia);
		o.alpha = round255(a * 255 + dst.alpha * ia);
		return o;
	endfunction

	// edge x at row ry as a rational num / den
	function automatic void edge_at(longint ax, longint ay, longint bx, longint by,
	                                longint ry, output longint num, output longint den);
		num = ax * (by - ay) + (bx - ax) * (ry - ay);
		den = 16 * (by - ay);
	endfunction

	function automatic void raster_draw(logic [143:0] d);
		longint vx [3];
		longint vy [3];
		longint t, top, bot, ry, ln, ld, sn, sd, lo, hi, xs, xe, addr;
		rgba_t src;
		int k;
		src = rgba_t'(d[127:96]);
		if (src.alpha == 0)
			return;
		for (int i = 0; i < 3; i++) begin
			vx[i] = longint'($signed(d[32*i +: 16]));
			vy[i] = longint'($signed(d[32*i+16 +: 16]));
		end
		for (int j = 0; j < 3; j++) begin
			k = (j == 1) ? 1 : 0;
			if (vy[k] > vy[k+1]) begin
				t = vx[k]; vx[k] = vx[k+1]; vx[k+1] = t;
				t = vy[k]; vy[k] = vy[k+1]; vy[k+1] = t;
			end
		end
		top = cdiv(vy[0], 16);
		if (top < 0) top = 0;
		bot = fdiv(vy[2], 16);
		if (bot > FRAME_HEIGHT - 1) bot = FRAME_HEIGHT - 1;
		if (top > bot || vy[2] - vy[0] < HALF_PIXEL)
			return;
		for (longint y = top; y <= bot; y++) begin
			ry = y * 16;
			edge_at(vx[0], vy[0], vx[2], vy[2], ry, ln, ld);
			if (ry < vy[1]) begin
				if (vy[1] - vy[0] > HALF_PIXEL)
					edge_at(vx[0], vy[0], vx[1], vy[1], ry, sn, sd);
				else begin
					sn = vx[1]; sd = 16;
				end
			end else begin
				if (vy[2] - vy[1] > HALF_PIXEL)
					edge_at(vx[1], vy[1], vx[2], vy[2], ry, sn, sd);
				else begin
					sn = vx[2]; sd = 16;
				end
			end
			lo = cdiv(ln, ld);
			t = cdiv(sn, sd);
			if (t < lo) lo = t;
			hi = fdiv(ln, ld);
			t = fdiv(sn, sd);
			if (t > hi) hi = t;
			xs = (lo < 0) ? 0 : lo;
			xe = (hi > FRAME_WIDTH - 1) ? FRAME_WIDTH - 1 : hi;
			for (longint x = xs; x <= xe; x++) begin
				addr = y * FRAME_WIDTH + x;
				if (addr >= 0 && addr < STORE_DEPTH)
					shadow_frame[addr] = mix_pixel(shadow_frame[addr], src);
			end
		end
	endfunction

	initial begin
		fail_count = 0;
		foreach (shadow_frame[i])
			shadow_frame[i] = '0;
	end

	assign pixels_pending = pixels_due.size();

	always @(posedge clk) begin
		rgba_t want, got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == OP_READ)
					pixels_due.push_back(shadow_frame[s_axis_tdata[139:128]]);
				else
					raster_draw(s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = rgba_t'(m_axis_tdata);
				if (pixels_due.size() == 0) begin
					$error("read result transfer with no read pending: %h", m_axis_tdata);
					fail_count++;
				end else begin
					want = pixels_due.pop_front();
					if (got.red !== want.red) begin
						$error("read_red expected %0d actual %0d", want.red, got.red);
						fail_count++;
					end
					if (got.green !== want.green) begin
						$error("read_green expected %0d actual %0d", want.green, got.green);
						fail_count++;
					end
					if (got.blue !== want.blue) begin
						$error("read_blue expected %0d actual %0d", want.blue, got.blue);
						fail_count++;
					end
					if (got.alpha !== want.alpha) begin
						$error("read_alpha expected %0d actual %0d", want.alpha, got.alpha);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

### tb/tb.sv
// tb: stimulus and verdict for triangle_scanline_alpha_fill; directed draws and
// reads, then random ones, with random stalls on both channels
// depends on tsaf_pkg, the block and tsaf_checker
`timescale 1ns / 1ps

module tb import tsaf_pkg::*; ();

	localparam longint CYCLE_LIMIT = 4000000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata;
	logic         s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [31:0]  m_axis_tdata;
	int           fail_count;
	int           pixels_pending;
	longint       cycle_count;
	int           items_sent;

	triangle_scanline_alpha_fill uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	tsaf_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.fail_count(fail_count), .pixels_pending(pixels_pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("triangle_scanline_alpha_fill test failed");
				$finish;
			end
		end
	end

	// receiver: sparse random stalls, one long hold-off, one quiet stretch
	initial begin
		longint rx_cycles;
		rx_cycles = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			rx_cycles++;
			if (rx_cycles >= 9000 && rx_cycles < 12000)
				m_axis_tready <= 1'b0;
			else if (rx_cycles >= 60000 && rx_cycles < 120000)
				m_axis_tready <= 1'b1;
			else
				m_axis_tready <= ($urandom_range(99) >= 8);
		end
	end

	function automatic logic [143:0] pack_draw(int x0, int y0, int x1, int y1, int x2, int y2,
	                                           logic [31:0] color);
		logic [143:0] d;
		d = '0;
		d[15:0] = 16'(x0);   d[31:16] = 16'(y0);
		d[47:32] = 16'(x1);  d[63:48] = 16'(y1);
		d[79:64] = 16'(x2);  d[95:80] = 16'(y2);
		d[127:96] = color;
		d[139:128] = 12'($urandom);
		return d;
	endfunction

	function automatic logic [143:0] pack_read(int index);
		logic [143:0] d;
		d = {4'b0, 12'(index), {4{$urandom}}};
		return d;
	endfunction

	task automatic transfer(logic op, logic [143:0] data);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= data;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		if (!(items_sent >= 70 && items_sent < 100) && $urandom_range(99) < 8) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// coordinates in 1/16 pixel, mostly small triangles near the frame
	task automatic random_draw();
		int cx, cy, sz, pick;
		logic [31:0] color;
		color = $urandom;
		if ($urandom_range(9) == 0)
			color[31:24] = ($urandom_range(1)) ? 8'd255 : 8'd0;
		pick = $urandom_range(99);
		if (pick < 15) begin
			transfer(OP_DRAW, {4'b0, 12'($urandom), color, 32'($urandom),
			                   32'($urandom), 32'($urandom)});
		end else begin
			sz = (pick < 25) ? 1100 : 200;
			cx = $urandom_range(0, 1100) - 80;
			cy = $urandom_range(0, 1100) - 80;
			transfer(OP_DRAW, pack_draw(cx + $urandom_range(sz), cy + $urandom_range(sz),
			                            cx + $urandom_range(sz), cy + $urandom_range(sz),
			                            cx + $urandom_range(sz), cy + $urandom_range(sz),
			                            color));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = OP_DRAW;
		s_axis_tdata = '0;
		items_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// untouched store reads as zero
		transfer(OP_READ, pack_read(0));
		transfer(OP_READ, pack_read(4095));
		// whole frame, opaque
		transfer(OP_DRAW, pack_draw(-16, -16, 2100, -16, -16, 2100, 32'hFF10_80F0));
		transfer(OP_READ, pack_read(0));
		transfer(OP_READ, pack_read(4095));
		// zero alpha draws nothing
		transfer(OP_DRAW, pack_draw(0, 0, 1000, 0, 0, 1000, 32'h00FF_FFFF));
		// flat, under half a pixel tall
		transfer(OP_DRAW, pack_draw(0, 100, 500, 107, 200, 103, 32'h80FF_FFFF));
		// entirely above the frame: empty row range
		transfer(OP_DRAW, pack_draw(0, -200, 500, -100, 200, -50, 32'h80FF_FFFF));
		// short top segment, equal y ties
		transfer(OP_DRAW, pack_draw(100, 160, 300, 166, 200, 400, 32'h7F00_FF00));
		transfer(OP_DRAW, pack_draw(50, 320, 250, 320, 150, 640, 32'h4020_4060));
		// short bottom segment
		transfer(OP_DRAW, pack_draw(400, 160, 600, 480, 500, 488, 32'hC011_2233));
		// extreme coordinates
		transfer(OP_DRAW, pack_draw(-32768, -32768, 32767, 32767, -32768, 32767,
		                            32'h0180_0000));
		transfer(OP_DRAW, pack_draw(32767, -32768, -32768, 32767, 32767, 32767,
		                            32'hFE00_FF80));
		transfer(OP_READ, pack_read(64 * 10 + 12));
		transfer(OP_READ, pack_read(64 * 21 + 10));
		transfer(OP_READ, pack_read(64 * 30 + 31));
		transfer(OP_READ, pack_read(2048));
		transfer(OP_READ, pack_read(4095));
		transfer(OP_READ, pack_read(63));

		for (int n = 0; n < 120; n++) begin
			if ($urandom_range(1))
				transfer(OP_READ, pack_read($urandom_range(4095)));
			else
				random_draw();
		end
		transfer(OP_READ, pack_read($urandom_range(4095)));
		s_axis_tvalid <= 1'b0;

		while (pixels_pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pixels_pending == 0)
			$display("triangle_scanline_alpha_fill test passed");
		else
			$display("triangle_scanline_alpha_fill test failed");
		$finish;
	end

endmodule
